[hw/rtl/aabb_push_out_resolver_core_defines.svh]
// assertion helpers for the push-out resolver
`ifndef AABB_PUSH_OUT_RESOLVER_CORE_DEFINES_SVH
`define AABB_PUSH_OUT_RESOLVER_CORE_DEFINES_SVH

// property that holds on every clock edge outside reset
`define APR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// same property but also checked during reset
`define APR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[hw/rtl/apr_pkg.sv]
package apr_pkg;

    localparam int unsigned CoordW = 32;
    localparam int unsigned ExtW   = 31;
    localparam int unsigned QuatW  = 16;
    localparam int unsigned RegW   = 21;
    localparam int unsigned RelW   = 17;
    localparam int unsigned WideW  = 64;

    localparam logic [RegW-1:0] HalfWidthRst    = 21'd19661;
    localparam logic [RegW-1:0] StandHeightRst  = 21'd117965;
    localparam logic [RegW-1:0] CrouchHeightRst = 21'd65536;
    localparam logic [RelW-1:0] GroundRelRst    = 17'd655;

    localparam logic [1:0] RegHalfWidth    = 2'd0;
    localparam logic [1:0] RegStandHeight  = 2'd1;
    localparam logic [1:0] RegCrouchHeight = 2'd2;
    localparam logic [1:0] RegGroundRel    = 2'd3;

    localparam logic OpStart = 1'b0;
    localparam logic OpBox   = 1'b1;

    localparam logic [2:0] ContactNone    = 3'd0;
    localparam logic [2:0] ContactPushX   = 3'd1;
    localparam logic [2:0] ContactPushZ   = 3'd2;
    localparam logic [2:0] ContactCeiling = 3'd3;
    localparam logic [2:0] ContactLanded  = 3'd4;
    localparam logic [2:0] ContactFloor   = 3'd5;

    // multiply-accumulate unit command
    typedef struct packed {
        logic               clear;
        logic               en;
        logic signed [33:0] a;
        logic signed [33:0] b;
    } t_mac_cmd;

endpackage

[hw/rtl/apr_mac.sv]
// shared signed multiply-accumulate, one product per cycle while en is set
module apr_mac (
    input  logic                    i_clk,
    input  apr_pkg::t_mac_cmd       i_cmd,
    output logic signed [63:0]      o_acc
);
    logic signed [63:0] r_acc;
    logic signed [67:0] w_prod;

    assign w_prod = i_cmd.a * i_cmd.b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            if (i_cmd.clear) begin
                r_acc <= w_prod[63:0];
            end else begin
                r_acc <= r_acc + w_prod[63:0];
            end
        end
    end

    assign o_acc = r_acc;
endmodule

[hw/rtl/aabb_push_out_resolver_core.sv]
// Player box push-out resolver. A start item (op 0) loads the player foot and
// flags and applies the floor at y=0 directly into the output register. A box
// item (op 1) drives one shared 34x34 multiply-accumulate unit to form the nine
// rotation terms and nine magnitude*extent products in sequence, then the overlap
// and least-penetration push are resolved in three more steps. One result per
// item is held in an output register; the next item is taken once it leaves.
`include "aabb_push_out_resolver_core_defines.svh"
module aabb_push_out_resolver_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [20:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_op,
    input  logic signed [31:0]   i_center_x,
    input  logic signed [31:0]   i_center_y,
    input  logic signed [31:0]   i_center_z,
    input  logic [30:0]          i_extent_x,
    input  logic [30:0]          i_extent_y,
    input  logic [30:0]          i_extent_z,
    input  logic signed [15:0]   i_quat_w,
    input  logic signed [15:0]   i_quat_x,
    input  logic signed [15:0]   i_quat_y,
    input  logic signed [15:0]   i_quat_z,
    input  logic [1:0]           i_start_flags,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [31:0]   o_pos_x,
    output logic signed [31:0]   o_pos_y,
    output logic signed [31:0]   o_pos_z,
    output logic                 o_grounded,
    output logic [2:0]           o_contact
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ROT   = 6'b000010,
        S_HALF  = 6'b000100,
        S_BOUND = 6'b001000,
        S_PEN   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [4:0] r_step;

    logic [20:0] r_half_width, r_stand, r_crouch;
    logic [16:0] r_release;

    logic signed [31:0] r_px, r_py, r_pz;
    logic r_ground, r_crouch_flag;

    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [30:0] r_ex, r_ey, r_ez;
    logic signed [15:0] r_qw, r_qx, r_qy, r_qz;

    logic [20:0] r_mag [9];  // rounded |matrix entry|, Q16
    logic signed [63:0] r_h [3];
    logic signed [63:0] r_nx, r_qxp, r_ny, r_qyp, r_nz, r_qzp;
    logic r_hit;

    logic signed [31:0] r_opx, r_opy, r_opz;
    logic r_og, r_ov;
    logic [2:0] r_oc;

    apr_pkg::t_mac_cmd w_cmd;
    logic signed [63:0] w_acc;

    apr_mac u_mac (.i_clk(i_clk), .i_cmd(w_cmd), .o_acc(w_acc));

    // rotation entry e = base - 2*(p0*q0 + s*p1*q1) on the diagonal, else 2*(...), over steps
    // each entry uses 2 products; step k: entry k/2, part k%2
    logic [3:0] w_ent;
    logic w_part;
    logic signed [15:0] w_a0, w_b0, w_a1, w_b1;
    logic w_neg1;

    assign w_ent  = r_step[4:1];
    assign w_part = r_step[0];

    always_comb begin
        w_a0 = r_qy; w_b0 = r_qy; w_a1 = r_qz; w_b1 = r_qz; w_neg1 = 1'b0;
        case (w_ent)
            4'd0: begin w_a0 = r_qy; w_b0 = r_qy; w_a1 = r_qz; w_b1 = r_qz; end
            4'd1: begin w_a0 = r_qx; w_b0 = r_qy; w_a1 = r_qw; w_b1 = r_qz;
                        w_neg1 = 1'b1; end
            4'd2: begin w_a0 = r_qx; w_b0 = r_qz; w_a1 = r_qw; w_b1 = r_qy; end
            4'd3: begin w_a0 = r_qx; w_b0 = r_qy; w_a1 = r_qw; w_b1 = r_qz; end
            4'd4: begin w_a0 = r_qx; w_b0 = r_qx; w_a1 = r_qz; w_b1 = r_qz; end
            4'd5: begin w_a0 = r_qy; w_b0 = r_qz; w_a1 = r_qw; w_b1 = r_qx;
                        w_neg1 = 1'b1; end
            4'd6: begin w_a0 = r_qx; w_b0 = r_qz; w_a1 = r_qw; w_b1 = r_qy;
                        w_neg1 = 1'b1; end
            4'd7: begin w_a0 = r_qy; w_b0 = r_qz; w_a1 = r_qw; w_b1 = r_qx; end
            4'd8: begin w_a0 = r_qx; w_b0 = r_qx; w_a1 = r_qy; w_b1 = r_qy; end
            default: ;
        endcase
    end

    // entry sitting in the accumulator is the one before the current step's
    logic [3:0] w_cap_ent;
    logic w_cap_diag;
    assign w_cap_ent  = (r_state == S_HALF) ? 4'd8 : (w_ent - 4'd1);
    assign w_cap_diag = (w_cap_ent == 4'd0) || (w_cap_ent == 4'd4) || (w_cap_ent == 4'd8);

    // entry value once both products are in: diag = 2^28 - 2*sum, else 2*sum
    logic signed [63:0] w_sum_full;
    logic signed [63:0] w_entry;
    logic [63:0] w_abs;
    logic [63:0] w_rnd;

    assign w_sum_full = w_acc;
    assign w_entry = w_cap_diag ? (64'sd268435456 - (w_sum_full <<< 1)) : (w_sum_full <<< 1);
    assign w_abs   = w_entry[63] ? 64'(-w_entry) : 64'(w_entry);
    assign w_rnd   = (w_abs + 64'd2048) >> 12;

    // half extent phase: step = axis*3 + term
    logic [1:0] w_hax, w_hterm;
    always_comb begin
        if (r_step < 5'd3) begin
            w_hax = 2'd0; w_hterm = r_step[1:0];
        end else if (r_step < 5'd6) begin
            w_hax = 2'd1; w_hterm = 2'(r_step - 5'd3);
        end else begin
            w_hax = 2'd2; w_hterm = 2'(r_step - 5'd6);
        end
    end

    logic [3:0] w_midx;
    logic [30:0] w_ext_sel;
    assign w_midx = 4'({2'b00, w_hax} * 4'd3 + {2'b00, w_hterm});
    always_comb begin
        case (w_hterm)
            2'd0: w_ext_sel = r_ex;
            2'd1: w_ext_sel = r_ey;
            default: w_ext_sel = r_ez;
        endcase
    end

    always_comb begin
        w_cmd = '0;
        case (r_state)
            S_ROT: begin
                w_cmd.en = 1'b1;
                w_cmd.clear = ~w_part;
                w_cmd.a = (w_part ? 34'(w_a1) : 34'(w_a0));
                w_cmd.b = (w_part ? (w_neg1 ? -34'(w_b1) : 34'(w_b1)) : 34'(w_b0));
            end
            S_HALF: begin
                w_cmd.en = 1'b1;
                w_cmd.clear = (w_hterm == 2'd0);
                w_cmd.a = {13'd0, r_mag[w_midx]};
                w_cmd.b = {3'd0, w_ext_sel};
            end
            default: ;
        endcase
    end

    // bounds
    logic signed [63:0] w_hgt;
    logic signed [63:0] w_pminx, w_pmaxx, w_pminy, w_pmaxy, w_pminz, w_pmaxz;
    logic signed [63:0] w_bminx, w_bmaxx, w_bminy, w_bmaxy, w_bminz, w_bmaxz;
    assign w_hgt   = r_crouch_flag ? 64'(r_crouch) : 64'(r_stand);
    assign w_pminx = 64'(r_px) - 64'(r_half_width);
    assign w_pmaxx = 64'(r_px) + 64'(r_half_width);
    assign w_pminy = 64'(r_py);
    assign w_pmaxy = 64'(r_py) + w_hgt;
    assign w_pminz = 64'(r_pz) - 64'(r_half_width);
    assign w_pmaxz = 64'(r_pz) + 64'(r_half_width);
    assign w_bminx = 64'(r_cx) - r_h[0];
    assign w_bmaxx = 64'(r_cx) + r_h[0];
    assign w_bminy = 64'(r_cy) - r_h[1];
    assign w_bmaxy = 64'(r_cy) + r_h[1];
    assign w_bminz = 64'(r_cz) - r_h[2];
    assign w_bmaxz = 64'(r_cz) + r_h[2];

    logic signed [63:0] w_ox, w_oy, w_oz, w_newv;
    logic signed [31:0] w_sat;
    assign w_ox = (r_nx < r_qxp) ? r_nx : r_qxp;
    assign w_oy = (r_ny < r_qyp) ? r_ny : r_qyp;
    assign w_oz = (r_nz < r_qzp) ? r_nz : r_qzp;

    logic [1:0] w_axis; // 0 x, 1 z, 2 y
    always_comb begin
        if (w_ox <= w_oy && w_ox <= w_oz) begin
            w_axis = 2'd0;
            w_newv = (r_nx < r_qxp) ? 64'(r_px) - w_ox : 64'(r_px) + w_ox;
        end else if (w_oz <= w_ox && w_oz <= w_oy) begin
            w_axis = 2'd1;
            w_newv = (r_nz < r_qzp) ? 64'(r_pz) - w_oz : 64'(r_pz) + w_oz;
        end else begin
            w_axis = 2'd2;
            w_newv = (r_ny < r_qyp) ? 64'(r_py) - w_oy : 64'(r_py) + w_oy;
        end
        if (w_newv > 64'sd2147483647) begin
            w_sat = 32'sh7fffffff;
        end else if (w_newv < -64'sd2147483648) begin
            w_sat = 32'sh80000000;
        end else begin
            w_sat = w_newv[31:0];
        end
    end

    logic w_in_xfer, w_out_xfer;
    assign o_ready    = (r_state == S_IDLE) && !r_ov;
    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_xfer = r_ov && i_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_xfer && i_op == apr_pkg::OpBox) n_state = S_ROT;
            S_ROT:   if (r_step == 5'd17) n_state = S_HALF;
            S_HALF:  if (r_step == 5'd8) n_state = S_BOUND;
            S_BOUND: n_state = S_PEN;
            S_PEN:   n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step <= '0;
            r_ov <= 1'b0;
            r_half_width <= apr_pkg::HalfWidthRst;
            r_stand <= apr_pkg::StandHeightRst;
            r_crouch <= apr_pkg::CrouchHeightRst;
            r_release <= apr_pkg::GroundRelRst;
            r_px <= '0; r_py <= '0; r_pz <= '0;
            r_ground <= 1'b1;
            r_crouch_flag <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    apr_pkg::RegHalfWidth:    r_half_width <= i_cfg_data;
                    apr_pkg::RegStandHeight:  r_stand <= i_cfg_data;
                    apr_pkg::RegCrouchHeight: r_crouch <= i_cfg_data;
                    apr_pkg::RegGroundRel:    r_release <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (w_out_xfer) r_ov <= 1'b0;
            if (r_state != n_state) begin
                r_step <= '0;
            end else begin
                r_step <= r_step + 5'd1;
            end
            if (w_in_xfer && i_op == apr_pkg::OpStart) begin
                r_px <= i_center_x;
                r_pz <= i_center_z;
                r_crouch_flag <= i_start_flags[0];
                r_ov <= 1'b1;
                r_opx <= i_center_x;
                r_opz <= i_center_z;
                if (i_center_y < 0) begin
                    r_py <= '0; r_opy <= '0;
                    r_ground <= 1'b1; r_og <= 1'b1;
                    r_oc <= apr_pkg::ContactFloor;
                end else begin
                    r_py <= i_center_y; r_opy <= i_center_y;
                    r_oc <= apr_pkg::ContactNone;
                    if (i_center_y > 32'sd0 + 32'($unsigned(r_release))) begin
                        r_ground <= 1'b0; r_og <= 1'b0;
                    end else begin
                        r_ground <= i_start_flags[1]; r_og <= i_start_flags[1];
                    end
                end
            end
            if (r_state == S_OUT) begin
                r_ov <= 1'b1;
                r_oc <= apr_pkg::ContactNone;
                r_opx <= r_px; r_opy <= r_py; r_opz <= r_pz;
                r_og <= r_ground;
                if (r_hit) begin
                    case (w_axis)
                        2'd0: begin
                            r_px <= w_sat; r_opx <= w_sat; r_oc <= apr_pkg::ContactPushX;
                        end
                        2'd1: begin
                            r_pz <= w_sat; r_opz <= w_sat; r_oc <= apr_pkg::ContactPushZ;
                        end
                        default: begin
                            r_py <= w_sat; r_opy <= w_sat;
                            if (r_ny < r_qyp) begin
                                r_oc <= apr_pkg::ContactCeiling;
                            end else begin
                                r_oc <= apr_pkg::ContactLanded;
                                r_ground <= 1'b1; r_og <= 1'b1;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_cx <= i_center_x; r_cy <= i_center_y; r_cz <= i_center_z;
            r_ex <= i_extent_x; r_ey <= i_extent_y; r_ez <= i_extent_z;
            r_qw <= i_quat_w; r_qx <= i_quat_x; r_qy <= i_quat_y; r_qz <= i_quat_z;
        end
        // the entry is written to r_mag from the accumulator once it has registered the entry's second product
        if ((r_state == S_ROT && !w_part && r_step != 5'd0) || (r_state == S_HALF
                && r_step == 5'd0)) begin
            r_mag[w_cap_ent] <= w_rnd[20:0];
        end
        if ((r_state == S_HALF && w_hterm == 2'd0 && r_step != 5'd0) ||
                r_state == S_BOUND) begin
            r_h[2'((r_state == S_BOUND) ? 2'd2 : w_hax - 2'd1)] <=
                (w_acc + 64'sd32768) >>> 16;
        end
        if (r_state == S_PEN) begin
            r_hit <= !(w_pmaxx <= w_bminx || w_pminx >= w_bmaxx) &&
                     !(w_pmaxy <= w_bminy || w_pminy >= w_bmaxy) &&
                     !(w_pmaxz <= w_bminz || w_pminz >= w_bmaxz);
            r_nx <= w_pmaxx - w_bminx; r_qxp <= w_bmaxx - w_pminx;
            r_ny <= w_pmaxy - w_bminy; r_qyp <= w_bmaxy - w_pminy;
            r_nz <= w_pmaxz - w_bminz; r_qzp <= w_bmaxz - w_pminz;
        end
    end

    assign o_valid    = r_ov;
    assign o_pos_x    = r_opx;
    assign o_pos_y    = r_opy;
    assign o_pos_z    = r_opz;
    assign o_grounded = r_og;
    assign o_contact  = r_oc;

    `APR_ASSERT(a_no_accept_busy, (r_state != S_IDLE) |-> !o_ready, "ready while busy")
    `APR_ASSERT(a_out_hold, (o_valid && !i_ready) |=> (o_valid && $stable(o_contact)), "result lost")
    `APR_ASSERT(a_contact_range, o_valid |-> (o_contact <= apr_pkg::ContactFloor), "bad contact")
    `APR_ASSERT_ALWAYS(a_state_onehot, $onehot(r_state) || !i_rst_n, "state code")
endmodule
